// ===== rtl/tower_pulse_timing_classifier_macros.svh =====
// Assertion helpers shared by the classifier RTL.
// Both expect signals named clk and rst_n in the calling scope.
`ifndef TOWER_PULSE_TIMING_CLASSIFIER_MACROS_SVH
`define TOWER_PULSE_TIMING_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tpt_pkg.sv =====
`default_nettype none

package tpt_pkg;

  // Sample and counter geometry
  localparam int SAMPLE_BITS = 10;
  localparam int NUM_SLICES  = 5;
  localparam int MAX_TOWERS  = 8192;
  localparam int CNT_W       = $clog2(MAX_TOWERS);
  localparam int CUT_W       = 13;
  localparam int CMP_W       = (CNT_W > CUT_W) ? CNT_W : CUT_W;
  localparam int TOTAL_W     = 16;
  localparam int SLICE_W     = 3;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = (CUT_W > SAMPLE_BITS) ? CUT_W : SAMPLE_BITS;

  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_TOWERS - 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Signed arithmetic for the quality check
  localparam int QW = SAMPLE_BITS + 6;
  typedef logic signed [QW-1:0] qval_t;
  localparam qval_t PEDESTAL = qval_t'(32);
  localparam qval_t K_THREE  = qval_t'(3);
  localparam qval_t K_FIVE   = qval_t'(5);
  localparam qval_t K_EIGHT  = qval_t'(8);

  // Reset values of the configuration registers
  localparam logic [SAMPLE_BITS-1:0] RST_LOW_THR   = SAMPLE_BITS'(70);
  localparam logic [CUT_W-1:0]       RST_MAX_MIS   = CUT_W'(4);
  localparam logic [CUT_W-1:0]       RST_MAX_BAD_E = CUT_W'(4);
  localparam logic [CUT_W-1:0]       RST_MAX_BAD_L = CUT_W'(4);
  localparam logic [CUT_W-1:0]       RST_MIN_GOOD_L = CUT_W'(2);
  localparam logic [CUT_W-1:0]       RST_MAX_GOOD_E = CUT_W'(2);

  localparam logic [SLICE_W-1:0] SLICE_EARLY = SLICE_W'(2);
  localparam logic [SLICE_W-1:0] SLICE_LATE  = SLICE_W'(3);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [2:0] {
    CAT_LOW       = 3'd0,
    CAT_SATURATED = 3'd1,
    CAT_MISPLACED = 3'd2,
    CAT_GOOD_S2   = 3'd3,
    CAT_BAD_S2    = 3'd4,
    CAT_GOOD_S3   = 3'd5,
    CAT_BAD_S3    = 3'd6
  } cat_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_LOW_THR    = 3'd0,
    REG_MAX_MIS    = 3'd1,
    REG_MAX_BAD_E  = 3'd2,
    REG_MAX_BAD_L  = 3'd3,
    REG_MIN_GOOD_L = 3'd4,
    REG_MAX_GOOD_E = 3'd5
  } reg_idx_t;

  typedef struct packed {
    sample_t sample_0;
    sample_t sample_1;
    sample_t sample_2;
    sample_t sample_3;
    sample_t sample_4;
    logic    last_tower;
  } in_data_t;

  typedef struct packed {
    cat_t                 category;
    logic [SLICE_W-1:0]   peak_slice;
    logic                 event_done;
    logic                 event_accept;
    logic [TOTAL_W-1:0]   selected_total;
  } out_data_t;

  // Classifier verdict for one tower
  typedef struct packed {
    cat_t               cat;
    logic [SLICE_W-1:0] peak;
  } cls_t;

  // Event cut thresholds
  typedef struct packed {
    logic [CUT_W-1:0] max_mis;
    logic [CUT_W-1:0] max_bad_e;
    logic [CUT_W-1:0] max_bad_l;
    logic [CUT_W-1:0] min_good_l;
    logic [CUT_W-1:0] max_good_e;
  } cuts_t;

  // Event outcome for the tower being retired
  typedef struct packed {
    logic               done;
    logic               accept;
    logic [TOTAL_W-1:0] total;
  } evt_t;

endpackage

`default_nettype wire

// ===== rtl/tower_pulse_timing_classifier.sv =====
// Pipeline: input register, then result register, between input transfer and result transfer.
// Throughput: one tower per cycle while out_stall is low, set by the single classify pass.
// A result waiting on out_stall blocks the next input transfer only once stage 1 also holds a tower.
// Reset (rst_n low, synchronous): pipeline empties, event counters and the accepted
// event count clear, configuration registers return to their defaults.
`default_nettype none

`include "tower_pulse_timing_classifier_macros.svh"

module tower_pulse_timing_classifier
  import tpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_data_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_data_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic                   s1_valid_r;
  in_data_t               s1_data_r;
  logic                   out_valid_r;
  out_data_t              out_data_r;
  logic [SAMPLE_BITS-1:0] thr_r;
  cuts_t                  cuts_r;
  logic                   adv, in_xfer, move;
  cls_t                   cls;
  evt_t                   evt;

  // Pipeline flow control
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;
  assign move     = s1_valid_r && adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r             <= RST_LOW_THR;
      cuts_r.max_mis    <= RST_MAX_MIS;
      cuts_r.max_bad_e  <= RST_MAX_BAD_E;
      cuts_r.max_bad_l  <= RST_MAX_BAD_L;
      cuts_r.min_good_l <= RST_MIN_GOOD_L;
      cuts_r.max_good_e <= RST_MAX_GOOD_E;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LOW_THR:    thr_r             <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_MAX_MIS:    cuts_r.max_mis    <= cfg_wdata[CUT_W-1:0];
        REG_MAX_BAD_E:  cuts_r.max_bad_e  <= cfg_wdata[CUT_W-1:0];
        REG_MAX_BAD_L:  cuts_r.max_bad_l  <= cfg_wdata[CUT_W-1:0];
        REG_MIN_GOOD_L: cuts_r.min_good_l <= cfg_wdata[CUT_W-1:0];
        REG_MAX_GOOD_E: cuts_r.max_good_e <= cfg_wdata[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) s1_valid_r <= 1'b1;
      else if (adv) s1_valid_r <= 1'b0;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) s1_data_r <= in_data;
    if (move) begin
      out_data_r.category       <= cls.cat;
      out_data_r.peak_slice     <= cls.peak;
      out_data_r.event_done     <= evt.done;
      out_data_r.event_accept   <= evt.accept;
      out_data_r.selected_total <= evt.total;
    end
  end

  tpt_classify u_classify (
    .item    (s1_data_r),
    .low_thr (thr_r),
    .cls     (cls)
  );

  tpt_event u_event (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (move),
    .cls   (cls),
    .last  (s1_data_r.last_tower),
    .cuts  (cuts_r),
    .evt   (evt)
  );

  `TPT_ASSERT_IMP(a_accept_done, out_valid_r, !out_data_r.event_accept || out_data_r.event_done, "accept without event done")
  `TPT_ASSERT_IMP(a_no_stall_empty, !out_valid_r, !in_stall, "input stalled with empty result register")

endmodule

`default_nettype wire

// ===== rtl/tpt_classify.sv =====
`default_nettype none

module tpt_classify
  import tpt_pkg::*;
(
  input  in_data_t                 item,
  input  logic [SAMPLE_BITS-1:0]   low_thr,
  output cls_t                     cls
);

  sample_t            smp [NUM_SLICES];
  sample_t            mx;
  logic [SLICE_W-1:0] pk;
  sample_t            a, b, c;
  qval_t              as, bs, cs;
  qval_t              d, diff, n, e;
  logic               tim_ok, wid_ok, good;

  assign smp[0] = item.sample_0;
  assign smp[1] = item.sample_1;
  assign smp[2] = item.sample_2;
  assign smp[3] = item.sample_3;
  assign smp[4] = item.sample_4;

  // First maximum: later slices win only when strictly larger
  always_comb begin
    mx = smp[0];
    pk = '0;
    for (int i = 1; i < NUM_SLICES; i++) begin
      if (smp[i] > mx) begin
        mx = smp[i];
        pk = SLICE_W'(i);
      end
    end
  end

  // Samples around the peak; only peaks in slices 2 and 3 are ever used
  assign a = (pk == SLICE_EARLY) ? smp[1] : smp[2];
  assign b = (pk == SLICE_EARLY) ? smp[2] : smp[3];
  assign c = (pk == SLICE_EARLY) ? smp[3] : smp[4];

  assign as = $signed(QW'(a));
  assign bs = $signed(QW'(b));
  assign cs = $signed(QW'(c));

  assign d    = as + cs - (bs <<< 1);
  assign diff = as - cs;
  assign n    = as + cs - (PEDESTAL <<< 1);
  assign e    = bs - PEDESTAL;

  // Timing in [0, 0.3]; flat top passes
  always_comb begin
    tim_ok = 1'b1;
    if (d > 0) begin
      if (diff < 0 || diff * K_FIVE > d * K_THREE) tim_ok = 1'b0;
    end else if (d < 0) begin
      if (diff > 0 || diff * K_FIVE < d * K_THREE) tim_ok = 1'b0;
    end
  end

  // Width in [1.0, 1.6]; at the pole only n == 0 passes
  always_comb begin
    wid_ok = 1'b1;
    if (e > 0) begin
      if (n < e || n * K_FIVE > e * K_EIGHT) wid_ok = 1'b0;
    end else if (e < 0) begin
      if (n > e || n * K_FIVE < e * K_EIGHT) wid_ok = 1'b0;
    end else begin
      if (n != 0) wid_ok = 1'b0;
    end
  end

  assign good = tim_ok && wid_ok;

  // Category: low first, then saturated, then by peak slice
  always_comb begin
    cls.peak = pk;
    if (mx < low_thr) begin
      cls.cat = CAT_LOW;
    end else if (mx == '1) begin
      cls.cat = CAT_SATURATED;
    end else if (pk == SLICE_EARLY) begin
      cls.cat = good ? CAT_GOOD_S2 : CAT_BAD_S2;
    end else if (pk == SLICE_LATE) begin
      cls.cat = good ? CAT_GOOD_S3 : CAT_BAD_S3;
    end else begin
      cls.cat = CAT_MISPLACED;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tpt_event.sv =====
`default_nettype none

`include "tower_pulse_timing_classifier_macros.svh"

module tpt_event
  import tpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  upd,
  input  cls_t  cls,
  input  logic  last,
  input  cuts_t cuts,
  output evt_t  evt
);

  logic [CNT_W-1:0]   mis_r, bad_e_r, good_e_r, bad_l_r, good_l_r;
  logic [CNT_W-1:0]   mis_nxt, bad_e_nxt, good_e_nxt, bad_l_nxt, good_l_nxt;
  logic [TOTAL_W-1:0] acc_r, acc_nxt;
  logic               pass;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v, input logic hit);
    bump = (hit && v != CNT_MAX) ? v + 1'b1 : v;
  endfunction

  // Counts including this tower
  assign mis_nxt    = bump(mis_r,    cls.cat == CAT_MISPLACED);
  assign good_e_nxt = bump(good_e_r, cls.cat == CAT_GOOD_S2);
  assign bad_e_nxt  = bump(bad_e_r,  cls.cat == CAT_BAD_S2);
  assign good_l_nxt = bump(good_l_r, cls.cat == CAT_GOOD_S3);
  assign bad_l_nxt  = bump(bad_l_r,  cls.cat == CAT_BAD_S3);

  // Event cuts
  assign pass = (CMP_W'(mis_nxt)    <= CMP_W'(cuts.max_mis))
             && (CMP_W'(bad_e_nxt)  <= CMP_W'(cuts.max_bad_e))
             && (CMP_W'(bad_l_nxt)  <= CMP_W'(cuts.max_bad_l))
             && (CMP_W'(good_l_nxt) >= CMP_W'(cuts.min_good_l))
             && (CMP_W'(good_e_nxt) <= CMP_W'(cuts.max_good_e));

  assign acc_nxt = (last && pass && acc_r != TOTAL_MAX) ? acc_r + 1'b1 : acc_r;

  assign evt.done   = last;
  assign evt.accept = last && pass;
  assign evt.total  = acc_nxt;

  // Counter update on each retired tower; last tower clears the event
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mis_r    <= '0;
      bad_e_r  <= '0;
      good_e_r <= '0;
      bad_l_r  <= '0;
      good_l_r <= '0;
      acc_r    <= '0;
    end else if (upd) begin
      acc_r <= acc_nxt;
      if (last) begin
        mis_r    <= '0;
        bad_e_r  <= '0;
        good_e_r <= '0;
        bad_l_r  <= '0;
        good_l_r <= '0;
      end else begin
        mis_r    <= mis_nxt;
        bad_e_r  <= bad_e_nxt;
        good_e_r <= good_e_nxt;
        bad_l_r  <= bad_l_nxt;
        good_l_r <= good_l_nxt;
      end
    end
  end

  `TPT_ASSERT_NXT(a_evt_clear, upd && last, mis_r == '0 && bad_e_r == '0 && good_e_r == '0 && bad_l_r == '0 && good_l_r == '0, "event counters not cleared after last tower")
  `TPT_ASSERT_IMP(a_acc_mono, $past(rst_n), acc_r >= $past(acc_r), "accepted event count went down")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
  import tpt_pkg::*;
();

  localparam int LIMIT_CYCLES = 1000000;
  localparam int BASELINE     = 32;
  localparam int SETTLE       = 4;
  localparam int SHOW_MAX     = 200;
  localparam logic [CFG_AW-1:0] REG_SPARE = 3'd6;
  localparam int FULL_SCALE   = (1 << SAMPLE_BITS) - 1;

  typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;
  typedef enum {SHAPE_PULSE, SHAPE_BAD, SHAPE_MISPLACED, SHAPE_LOW, SHAPE_SAT,
                SHAPE_NOISE} shape_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_data_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_data_t         out_data;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // towers waiting to be sent, and verdicts waiting to come back
  in_data_t  tower_q [$];
  out_data_t verdict_q [$];
  out_data_t head;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  // shadow of the configuration and of the event counters
  logic [SAMPLE_BITS-1:0] thr_cfg;
  cuts_t                  cut_cfg;
  logic [CNT_W-1:0]       mis_cnt, bad_e_cnt, good_e_cnt, bad_l_cnt, good_l_cnt;
  logic [TOTAL_W-1:0]     sel_total;

  tower_pulse_timing_classifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // pulse shape test: timing in [0, 0.3] and width in [1.0, 1.6], exact
  function automatic bit pulse_ok(int a, int b, int c);
    int d, n, e;
    bit ok;
    d = a + c - 2 * b;
    n = a + c - 2 * BASELINE;
    e = b - BASELINE;
    ok = 1'b1;
    if (d > 0) begin
      if (a - c < 0) ok = 1'b0;
      if (5 * (a - c) > 3 * d) ok = 1'b0;
    end else if (d < 0) begin
      if (a - c > 0) ok = 1'b0;
      if (5 * (a - c) < 3 * d) ok = 1'b0;
    end
    if (e > 0) begin
      if (n < e) ok = 1'b0;
      if (5 * n > 8 * e) ok = 1'b0;
    end else if (e < 0) begin
      if (n > e) ok = 1'b0;
      if (5 * n < 8 * e) ok = 1'b0;
    end else if (n != 0) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // classify one tower and update the event state
  function automatic out_data_t classify_tower(in_data_t t);
    sample_t s [NUM_SLICES];
    int pk;
    bit good;
    bit pass;
    out_data_t r;
    s[0] = t.sample_0;
    s[1] = t.sample_1;
    s[2] = t.sample_2;
    s[3] = t.sample_3;
    s[4] = t.sample_4;
    r = '0;
    pass = 1'b0;
    pk = 0;
    for (int i = 1; i < NUM_SLICES; i++)
      if (s[i] > s[pk]) pk = i;

    if (s[pk] < thr_cfg) begin
      r.category = CAT_LOW;
    end else if (s[pk] == sample_t'(FULL_SCALE)) begin
      r.category = CAT_SATURATED;
    end else if (pk == 2) begin
      good = pulse_ok(int'(s[1]), int'(s[2]), int'(s[3]));
      if (good) begin
        good_e_cnt = sat_inc(good_e_cnt);
        r.category = CAT_GOOD_S2;
      end else begin
        bad_e_cnt = sat_inc(bad_e_cnt);
        r.category = CAT_BAD_S2;
      end
    end else if (pk == 3) begin
      good = pulse_ok(int'(s[2]), int'(s[3]), int'(s[4]));
      if (good) begin
        good_l_cnt = sat_inc(good_l_cnt);
        r.category = CAT_GOOD_S3;
      end else begin
        bad_l_cnt = sat_inc(bad_l_cnt);
        r.category = CAT_BAD_S3;
      end
    end else begin
      mis_cnt = sat_inc(mis_cnt);
      r.category = CAT_MISPLACED;
    end

    // event cuts on the closing tower
    if (t.last_tower) begin
      pass = mis_cnt <= cut_cfg.max_mis && bad_e_cnt <= cut_cfg.max_bad_e &&
             bad_l_cnt <= cut_cfg.max_bad_l && good_l_cnt >= cut_cfg.min_good_l &&
             good_e_cnt <= cut_cfg.max_good_e;
      if (pass && sel_total != TOTAL_MAX) sel_total = sel_total + 1'b1;
      mis_cnt = '0;
      bad_e_cnt = '0;
      good_e_cnt = '0;
      bad_l_cnt = '0;
      good_l_cnt = '0;
    end

    r.peak_slice = SLICE_W'(pk);
    r.event_done = t.last_tower;
    r.event_accept = pass;
    r.selected_total = sel_total;
    return r;
  endfunction

  // random tower of a given shape; pulses are built near the good region
  function automatic in_data_t make_tower(shape_t shape, bit last);
    int v [NUM_SLICES];
    int pk, a, b, c, e, n, sum;
    in_data_t t;
    pk = $urandom_range(3, 2);
    b = $urandom_range(1022, 40);
    for (int i = 0; i < NUM_SLICES; i++) v[i] = $urandom_range(b - 1, 0);
    case (shape)
      SHAPE_PULSE: begin
        e = b - BASELINE;
        n = $urandom_range((8 * e) / 5 + 1, e);
        sum = n + 2 * BASELINE;
        a = sum / 2 - int'($urandom_range(12, 0));
        c = sum - a;
        if (c > b) begin
          c = b;
          a = sum - b;
        end
        if (a < 0) a = 0;
        if (a >= b) a = b - 1;
        v[pk - 1] = a;
        v[pk] = b;
        v[pk + 1] = c;
      end
      SHAPE_BAD: begin
        v[pk] = b;
        v[pk - 1] = $urandom_range(b - 1, 0);
        v[pk + 1] = $urandom_range(b, 0);
      end
      SHAPE_MISPLACED: begin
        pk = $urandom_range(2, 0);
        if (pk == 2) pk = 4;
        v[pk] = b;
      end
      SHAPE_LOW: begin
        for (int i = 0; i < NUM_SLICES; i++)
          v[i] = (thr_cfg == 0) ? 0 : $urandom_range(int'(thr_cfg) - 1, 0);
      end
      SHAPE_SAT: begin
        v[$urandom_range(NUM_SLICES - 1, 0)] = FULL_SCALE;
      end
      default: begin
        for (int i = 0; i < NUM_SLICES; i++) v[i] = $urandom_range(FULL_SCALE, 0);
        last = 1'($urandom_range(1, 0));
      end
    endcase
    t.sample_0 = sample_t'(v[0]);
    t.sample_1 = sample_t'(v[1]);
    t.sample_2 = sample_t'(v[2]);
    t.sample_3 = sample_t'(v[3]);
    t.sample_4 = sample_t'(v[4]);
    t.last_tower = last;
    return t;
  endfunction

  function automatic shape_t pick_shape();
    int r;
    r = $urandom_range(99, 0);
    if (r < 45) return SHAPE_PULSE;
    if (r < 60) return SHAPE_BAD;
    if (r < 72) return SHAPE_MISPLACED;
    if (r < 82) return SHAPE_LOW;
    if (r < 87) return SHAPE_SAT;
    return SHAPE_NOISE;
  endfunction

  task automatic push_tower(int s0, int s1, int s2, int s3, int s4, bit last);
    in_data_t t;
    t.sample_0 = sample_t'(s0);
    t.sample_1 = sample_t'(s1);
    t.sample_2 = sample_t'(s2);
    t.sample_3 = sample_t'(s3);
    t.sample_4 = sample_t'(s4);
    t.last_tower = last;
    tower_q = {tower_q, t};
  endtask

  // events of mostly shaped towers, sometimes long ones; noise towers set last at random
  task automatic queue_events(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 12) : $urandom_range(8, 1);
      for (int j = 0; j < len; j++) tower_q = {tower_q, make_tower(pick_shape(), j == len - 1)};
      sent += len;
    end
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOW_THR:    thr_cfg = val[SAMPLE_BITS-1:0];
      REG_MAX_MIS:    cut_cfg.max_mis = val[CUT_W-1:0];
      REG_MAX_BAD_E:  cut_cfg.max_bad_e = val[CUT_W-1:0];
      REG_MAX_BAD_L:  cut_cfg.max_bad_l = val[CUT_W-1:0];
      REG_MIN_GOOD_L: cut_cfg.min_good_l = val[CUT_W-1:0];
      REG_MAX_GOOD_E: cut_cfg.max_good_e = val[CUT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_cuts(int thr, int mis, int bad_e, int bad_l, int good_l,
                              int good_e);
    write_reg(REG_LOW_THR, CFG_DW'(thr));
    write_reg(REG_MAX_MIS, CFG_DW'(mis));
    write_reg(REG_MAX_BAD_E, CFG_DW'(bad_e));
    write_reg(REG_MAX_BAD_L, CFG_DW'(bad_l));
    write_reg(REG_MIN_GOOD_L, CFG_DW'(good_l));
    write_reg(REG_MAX_GOOD_E, CFG_DW'(good_e));
    @(negedge clk);
  endtask

  task automatic set_pace(pace_t p);
    case (p)
      PACE_FULL:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      PACE_SEND_GAPS:   begin send_gap_pct = 51; recv_stall_pct = 0;  end
      PACE_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 51; end
      default:          begin send_gap_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  task automatic wait_drained();
    while (tower_q.size() != 0 || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic flag_field(string fld, logic [TOTAL_W-1:0] want,
                            logic [TOTAL_W-1:0] got);
    errors++;
    if (errors <= SHOW_MAX)
      $display("%0t ns: %s expected %0h, got %0h", $time, fld, want, got);
  endtask

  // input side: one tower per transfer, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        verdict_q = {verdict_q, classify_tower(in_data)};
        void'(tower_q.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (tower_q.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data <= tower_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: compare each transfer with the oldest verdict
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t ns: unexpected result %0h", $time, out_data);
      end else begin
        head = verdict_q.pop_front();
        if (out_data.category !== head.category)
          flag_field("category", TOTAL_W'(head.category), TOTAL_W'(out_data.category));
        if (out_data.peak_slice !== head.peak_slice)
          flag_field("peak_slice", TOTAL_W'(head.peak_slice), TOTAL_W'(out_data.peak_slice));
        if (out_data.event_done !== head.event_done)
          flag_field("event_done", TOTAL_W'(head.event_done), TOTAL_W'(out_data.event_done));
        if (out_data.event_accept !== head.event_accept)
          flag_field("event_accept", TOTAL_W'(head.event_accept),
                     TOTAL_W'(out_data.event_accept));
        if (out_data.selected_total !== head.selected_total)
          flag_field("selected_total", head.selected_total, out_data.selected_total);
      end
    end
    out_stall <= rst_n && ($urandom_range(99, 0) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    thr_cfg = RST_LOW_THR;
    cut_cfg = '{RST_MAX_MIS, RST_MAX_BAD_E, RST_MAX_BAD_L, RST_MIN_GOOD_L, RST_MAX_GOOD_E};
    mis_cnt = '0;
    bad_e_cnt = '0;
    good_e_cnt = '0;
    bad_l_cnt = '0;
    good_l_cnt = '0;
    sel_total = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed towers on the reset configuration
    set_pace(PACE_BOTH);
    push_tower(0, 0, 0, 0, 0, 0);
    push_tower(1023, 1023, 1023, 1023, 1023, 0);
    push_tower(0, 0, 1023, 0, 0, 0);
    push_tower(0, 0, 69, 0, 0, 0);
    push_tower(0, 0, 70, 0, 0, 0);
    push_tower(10, 336, 500, 336, 10, 0);
    push_tower(10, 20, 336, 500, 336, 0);
    push_tower(0, 0, 100, 500, 100, 0);
    push_tower(1, 2, 3, 4, 900, 0);
    push_tower(5, 900, 900, 3, 2, 0);
    push_tower(0, 0, 800, 800, 0, 0);
    // timing limit 0.3 on both sides
    push_tower(0, 260, 500, 440, 0, 0);
    push_tower(0, 259, 500, 440, 0, 0);
    // width limits 1.0 and 1.6 on both sides
    push_tower(0, 266, 500, 266, 0, 0);
    push_tower(0, 265, 500, 265, 0, 0);
    push_tower(0, 432, 532, 432, 0, 0);
    push_tower(0, 0, 433, 532, 433, 1);
    push_tower(0, 0, 336, 500, 336, 0);
    push_tower(0, 0, 336, 500, 336, 1);
    wait_drained();

    // zero threshold: width pole and widths below baseline; high bits masked
    program_cuts(13'h1C00, 0, 0, 0, 0, 0);
    push_tower(0, 0, 0, 0, 0, 0);
    push_tower(0, 31, 32, 30, 0, 0);
    push_tower(0, 10, 20, 10, 0, 0);
    push_tower(0, 31, 32, 32, 0, 1);
    wait_drained();

    // random events under several settings and pacings
    set_pace(PACE_FULL);
    program_cuts(70, $urandom_range(8, 0), $urandom_range(8, 0), $urandom_range(8, 0),
                 $urandom_range(4, 0), $urandom_range(6, 0));
    queue_events(230);
    wait_drained();

    set_pace(PACE_SEND_GAPS);
    program_cuts(0, 0, 0, 0, 0, 0);
    queue_events(230);
    wait_drained();

    set_pace(PACE_RECV_STALLS);
    program_cuts(1023, 8191, 8191, 8191, 8191, 8191);
    queue_events(230);
    wait_drained();

    set_pace(PACE_BOTH);
    write_reg(REG_SPARE, CFG_DW'($urandom));
    program_cuts($urandom_range(8191, 0), $urandom_range(6, 0), $urandom_range(6, 0),
                 $urandom_range(6, 0), $urandom_range(3, 0), $urandom_range(6, 0));
    queue_events(230);
    wait_drained();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
